### rtl/core/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared constants, constant helpers and stage payload types for the
// fixed-point sine/cosine unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

	// constants in millionths, scaled to the fixed-point format by fix_const
	localparam logic [63:0] HPI_MICRO   = 64'd1570796;
	localparam logic [63:0] PI_MICRO    = 64'd3141593;
	localparam logic [63:0] TWOPI_MICRO = 64'd6283185;
	localparam logic [63:0] PISQ_MICRO  = 64'd9869604;

	// quotient bits resolved per divider stage
	localparam int DIV_BITS_PER_STAGE = 2;

	function automatic logic [31:0] fix_const(input logic [63:0] micro, input int unsigned fb);
		logic [63:0] scaled;
		scaled = (micro << fb) / 64'd1000000;
		return scaled[31:0];
	endfunction

	// reduced angle leaving the range reduction
	typedef struct packed {
		logic [31:0] r;
		logic        flip;
	} fsc_red_t;

	// operands of the final division
	typedef struct packed {
		logic [31:0] mag;
		logic [31:0] den;
		logic        neg;
	} fsc_rat_t;

endpackage

`default_nettype wire

### rtl/core/fsc_req_if.sv
// ----------------------------------------------------------------------------
// fsc_req_if
// Request channel: operation select and angle, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsc_req_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [31:0] angle;

	modport source(output valid, output op, output angle, input ready);
	modport sink(input valid, input op, input angle, output ready);
endinterface

`default_nettype wire

### rtl/core/fsc_res_if.sv
// ----------------------------------------------------------------------------
// fsc_res_if
// Result channel: cosine or sine value, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsc_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

`default_nettype wire

### rtl/core/fixed_point_sine_cosine_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_sine_cosine_unit
// Fixed-point cosine/sine by the Bhaskara I rational approximation.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the skid entry is empty: op selects
// cosine (0) or sine (1) of a signed angle in radians with FRAC_BITS fraction
// bits, and each returns one value in the same format. The path runs through
// eight range-reduction stages, three stages for the square and the ratio
// operands, the divider with two quotient bits per stage plus its load stage,
// and the output register. A two-entry output stage lets the pipeline keep
// moving after the result side stalls, until the skid entry is full.
`default_nettype none

module fixed_point_sine_cosine_unit
	import fsc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	fsc_req_if.sink       req,
	fsc_res_if.source     res
);

	logic        en;
	logic        red_v, rat_v, div_v;
	fsc_red_t    red_d;
	fsc_rat_t    rat_d;
	logic [31:0] div_value;

	logic        out_v_q, skid_v_q;
	logic [31:0] out_d_q, skid_d_q;
	logic        arrive;

	assign en        = !skid_v_q;
	assign req.ready = en;
	assign arrive    = en && div_v;

	fsc_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req.valid),
		.op        (req.op),
		.angle     (req.angle),
		.out_valid (red_v),
		.out_data  (red_d)
	);

	fsc_ratio #(.FRAC_BITS(FRAC_BITS)) u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (red_v),
		.in_data   (red_d),
		.out_valid (rat_v),
		.out_data  (rat_d)
	);

	fsc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rat_v),
		.in_data   (rat_d),
		.out_valid (div_v),
		.out_value (div_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (res.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (arrive) begin
			if (out_v_q && !res.ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (res.ready) begin
				out_d_q <= skid_d_q;
			end
		end else if (arrive) begin
			if (out_v_q && !res.ready) begin
				skid_d_q <= div_value;
			end else begin
				out_d_q <= div_value;
			end
		end
	end

	assign res.valid = out_v_q;
	assign res.value = out_d_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without an output transaction");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && res.ready) |=> (out_v_q && !skid_v_q))
		else $error("skid entry not moved to output");

	a_stall_catches: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_v_q && div_v && out_v_q && !res.ready) |=> skid_v_q)
		else $error("pipeline result lost during output stall");

endmodule

`default_nettype wire

### rtl/core/fsc_reduce.sv
// ----------------------------------------------------------------------------
// fsc_reduce
// Eight-stage range reduction: angle modulo pi and modulo 2pi by
// reciprocal multiplication, giving the centered angle and the sign flip.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_reduce
	import fsc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic               op,
	input  wire logic signed [31:0] angle,
	output logic                    out_valid,
	output fsc_red_t                out_data
);

	localparam logic [31:0] K_HPI   = fix_const(HPI_MICRO, FRAC_BITS);
	localparam logic [31:0] K_PI    = fix_const(PI_MICRO, FRAC_BITS);
	localparam logic [31:0] K_TWOPI = fix_const(TWOPI_MICRO, FRAC_BITS);
	localparam logic [63:0] ONE_W   = 64'd1 << FRAC_BITS;
	localparam logic [63:0] REC_PI_W    = (64'd1 << 32) / {32'd0, K_PI};
	localparam logic [63:0] REC_TWOPI_W = (64'd1 << 32) / {32'd0, K_TWOPI};
	localparam logic [63:0] CEIL_PI_W    = ({32'd0, K_PI} + ONE_W - 64'd1) >> FRAC_BITS;
	localparam logic [63:0] CEIL_TWOPI_W = ({32'd0, K_TWOPI} + ONE_W - 64'd1) >> FRAC_BITS;

	localparam logic [31:0] KMOD [2] = '{K_PI, K_TWOPI};
	localparam logic [31:0] KREC [2] = '{REC_PI_W[31:0], REC_TWOPI_W[31:0]};
	localparam logic [31:0] KCEIL [2] = '{CEIL_PI_W[31:0], CEIL_TWOPI_W[31:0]};

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [31:0] x_s1;
	logic [31:0] xmag_s2, xmag_s3, xmag_s4;
	logic        xneg_s2, xneg_s3, xneg_s4, xneg_s5, xneg_s6;
	logic [31:0] qe_s3 [2];
	logic [31:0] qp_s4 [2];
	logic [31:0] b_s5 [2];
	logic [31:0] bc_s6 [2];
	logic [31:0] mod_s7 [2];
	fsc_red_t    red_s8;
	logic [63:0] rec_prod [2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			rec_prod[j] = 64'(xmag_s2) * 64'(KREC[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// sine shifts by -pi/2 which cancels the +pi/2 of the cosine
			x_s1 <= op ? angle : angle + K_HPI;

			xneg_s2 <= x_s1[31];
			xmag_s2 <= x_s1[31] ? 32'd0 - x_s1 : x_s1;

			xneg_s3 <= xneg_s2;
			xmag_s3 <= xmag_s2;
			xneg_s4 <= xneg_s3;
			xmag_s4 <= xmag_s3;
			xneg_s5 <= xneg_s4;
			xneg_s6 <= xneg_s5;

			for (int j = 0; j < 2; j++) begin
				// quotient estimate, at most one short
				qe_s3[j]  <= rec_prod[j][63:32];
				qp_s4[j]  <= qe_s3[j] * KMOD[j];
				b_s5[j]   <= xmag_s4 - qp_s4[j];
				bc_s6[j]  <= (b_s5[j] >= KMOD[j]) ? b_s5[j] - KMOD[j] : b_s5[j];
				// negative angles: quotient rounds away from zero unless the
				// remainder is below one lsb of the scaled quotient
				mod_s7[j] <= !xneg_s6 ? bc_s6[j] :
				             (bc_s6[j] >= KCEIL[j]) ? KMOD[j] - bc_s6[j] : 32'd0 - bc_s6[j];
			end

			red_s8.r    <= mod_s7[0] - K_HPI;
			red_s8.flip <= $signed(mod_s7[1]) > $signed(K_PI);
		end
	end

	assign out_valid = v_s8;
	assign out_data  = red_s8;

endmodule

`default_nettype wire

### rtl/core/fsc_ratio.sv
// ----------------------------------------------------------------------------
// fsc_ratio
// Three-stage square and numerator/denominator build of the rational
// approximation.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_ratio
	import fsc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     in_valid,
	input  wire fsc_red_t in_data,
	output logic          out_valid,
	output fsc_rat_t      out_data
);

	localparam logic [31:0] K_PISQ = fix_const(PISQ_MICRO, FRAC_BITS);

	logic        v_s1, v_s2, v_s3;
	logic [63:0] sq_s1;
	logic        flip_s1, flip_s2;
	logic [31:0] num_s2, den_s2;
	fsc_rat_t    rat_s3;
	logic [31:0] r2;

	// square is never negative, so the arithmetic shift is a plain select
	assign r2 = sq_s1[FRAC_BITS +: 32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1   <= 64'($signed(in_data.r)) * 64'($signed(in_data.r));
			flip_s1 <= in_data.flip;

			num_s2  <= K_PISQ - {r2[29:0], 2'b00};
			den_s2  <= K_PISQ + r2;
			flip_s2 <= flip_s1;

			rat_s3.mag <= num_s2[31] ? 32'd0 - num_s2 : num_s2;
			rat_s3.den <= den_s2;
			rat_s3.neg <= num_s2[31] ^ flip_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = rat_s3;

endmodule

`default_nettype wire

### rtl/core/fsc_div.sv
// ----------------------------------------------------------------------------
// fsc_div
// Pipelined restoring divider: (mag << FRAC_BITS) / den, DIV_BITS_PER_STAGE
// quotient bits per stage, then sign applied to the truncated quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_div
	import fsc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     in_valid,
	input  wire fsc_rat_t in_data,
	output logic          out_valid,
	output logic [31:0]   out_value
);

	// quotient magnitude stays below 2^(FRAC_BITS+4)
	localparam int NSTG = (FRAC_BITS + 8 + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
	localparam int QW   = NSTG * DIV_BITS_PER_STAGE;

	logic          v_s   [NSTG+1];
	logic [31:0]   rem_s [NSTG+1];
	logic [QW-1:0] dsh_s [NSTG+1];
	logic [QW-1:0] quo_s [NSTG+1];
	logic [31:0]   den_s [NSTG+1];
	logic          neg_s [NSTG+1];
	logic [63:0]   dividend;

	assign dividend = {32'd0, in_data.mag} << FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= 32'(dividend >> QW);
			dsh_s[0] <= dividend[QW-1:0];
			quo_s[0] <= '0;
			den_s[0] <= in_data.den;
			neg_s[0] <= in_data.neg;
		end
	end

	for (genvar k = 1; k <= NSTG; k++) begin : g_stage
		logic [31:0]   nrem;
		logic [QW-1:0] ndsh;
		logic [QW-1:0] nquo;

		always_comb begin
			logic [31:0] cand;
			nrem = rem_s[k-1];
			ndsh = dsh_s[k-1];
			nquo = quo_s[k-1];
			for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
				cand = {nrem[30:0], ndsh[QW-1]};
				ndsh = {ndsh[QW-2:0], 1'b0};
				if (cand >= den_s[k-1]) begin
					nrem = cand - den_s[k-1];
					nquo = {nquo[QW-2:0], 1'b1};
				end else begin
					nrem = cand;
					nquo = {nquo[QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= nrem;
				dsh_s[k] <= ndsh;
				quo_s[k] <= nquo;
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	logic [31:0] quo_ext;
	assign quo_ext   = 32'(quo_s[NSTG]);
	assign out_valid = v_s[NSTG];
	assign out_value = neg_s[NSTG] ? 32'd0 - quo_ext : quo_ext;

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point sine/cosine unit: directed and
// random angles are sent with bursty valid and a stalling result side, and
// every value is checked against a bit-exact Bhaskara approximation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fsc_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;

	localparam logic OP_COS = 1'b0;
	localparam logic OP_SIN = 1'b1;

	localparam longint K_HPI   = (64'd1570796 << FRAC_BITS) / 64'd1000000;
	localparam longint K_PI    = (64'd3141593 << FRAC_BITS) / 64'd1000000;
	localparam longint K_TWOPI = (64'd6283185 << FRAC_BITS) / 64'd1000000;
	localparam longint K_PISQ  = (64'd9869604 << FRAC_BITS) / 64'd1000000;

	typedef struct {
		logic        op;
		logic [31:0] angle;
	} angle_req_t;

	logic clk;
	logic arst_n;

	fsc_req_if req();
	fsc_res_if res();

	fixed_point_sine_cosine_unit #(.FRAC_BITS(FRAC_BITS)) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.res   (res)
	);

	angle_req_t  pending_q[$];
	logic [31:0] expected_values_q[$];
	int          fail_count = 0;
	int          idle_cycles = 0;
	bit          req_fired = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_mode = 0;
	int          stall_phase = 0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
		longint p;
		p = longint'($signed(a)) * longint'($signed(b));
		return 32'(p >>> FRAC_BITS);
	endfunction

	function automatic logic [31:0] fx_div(logic [31:0] a, logic [31:0] b);
		longint n;
		if (b == 32'd0) begin
			return 32'd0;
		end
		n = longint'($signed(a)) <<< FRAC_BITS;
		return 32'(n / longint'($signed(b)));
	endfunction

	function automatic logic [31:0] fx_mod(logic [31:0] a, logic [31:0] m);
		logic [31:0] q;
		q = fx_div(a, m) & ~((32'd1 << FRAC_BITS) - 32'd1);
		return a - fx_mul(q, m);
	endfunction

	function automatic logic [31:0] predict_trig(logic op, logic [31:0] angle);
		logic [31:0] t, x, r, r2, num, den, v;
		t = angle;
		if (op == OP_SIN) begin
			t = t - 32'(K_HPI);
		end
		x = t + 32'(K_HPI);
		r = fx_mod(x, 32'(K_PI)) - 32'(K_HPI);
		r2 = fx_mul(r, r);
		num = 32'(K_PISQ) - 32'd4 * r2;
		den = 32'(K_PISQ) + r2;
		v = fx_div(num, den);
		if ($signed(fx_mod(x, 32'(K_TWOPI))) > $signed(32'(K_PI))) begin
			v = 32'd0 - v;
		end
		return v;
	endfunction

	// sender: bursts and gaps, changes at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req.valid || req_fired) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req.valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					req.valid <= 1'b1;
					req.op <= pending_q[0].op;
					req.angle <= pending_q[0].angle;
					void'(pending_q.pop_front());
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
			// receiver stall pattern, switching style now and then
			stall_phase <= stall_phase + 1;
			if ($urandom_range(0, 99) == 0) begin
				stall_mode <= $urandom_range(0, 3);
			end
			case (stall_mode)
				0: res.ready <= 1'b1;
				1: res.ready <= (stall_phase % 5) != 0;
				2: res.ready <= 1'($urandom_range(0, 1));
				default: res.ready <= (stall_phase % 16) < 3;
			endcase
		end
	end

	// monitor and checker at the rising edge
	always @(posedge clk) begin
		req_fired <= req.valid && req.ready;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				expected_values_q.push_back(predict_trig(req.op, req.angle));
			end
			if (res.valid && res.ready) begin
				if (expected_values_q.size() == 0) begin
					$error("unexpected transaction: value actual %h", res.value);
					fail_count <= fail_count + 1;
				end else begin
					if (res.value !== expected_values_q[0]) begin
						$error("value mismatch: expected %h actual %h",
							expected_values_q[0], res.value);
						fail_count <= fail_count + 1;
					end
					void'(expected_values_q.pop_front());
				end
			end
			if ((req.valid && req.ready) || (res.valid && res.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	task automatic add_item(logic op, logic [31:0] angle);
		angle_req_t it;
		it.op = op;
		it.angle = angle;
		pending_q.push_back(it);
	endtask

	initial begin
		logic [31:0] directed[$];
		logic [31:0] a;
		int mode;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = OP_COS;
		req.angle = 32'd0;
		res.ready = 1'b0;
		directed = {32'd0, 32'h7fffffff, 32'h80000000, 32'd1, 32'hffffffff,
			32'(K_HPI), 32'(K_PI), 32'(K_TWOPI), -32'(K_PI), -32'(K_HPI),
			32'(K_PI) + 32'd1, 32'h7fffffff - 32'(K_HPI)};
		foreach (directed[i]) begin
			add_item(OP_COS, directed[i]);
			add_item(OP_SIN, directed[i]);
		end
		for (int i = 0; i < 700; i++) begin
			mode = $urandom_range(0, 9);
			if (mode < 6) begin
				// the usual range, up to four turns either way
				a = 32'($signed($urandom_range(0, 8 * K_TWOPI)) - 4 * K_TWOPI);
			end else if (mode < 8) begin
				a = $urandom();
			end else begin
				a = 32'(K_PI) * $urandom_range(0, 40) - 32'(20 * K_PI)
					+ 32'($signed($urandom_range(0, 6)) - 3);
			end
			add_item(1'($urandom_range(0, 1)), a);
		end
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		wait (pending_q.size() == 0 && !req.valid && expected_values_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
